>>> hdl/gfau_pkg.sv
package gfau_pkg;

  // field and operand geometry
  localparam int LO_W       = 64;
  localparam int HI_W       = 56;
  localparam int ELEM_W     = LO_W + HI_W;
  localparam int PROD_W     = 2 * ELEM_W - 1;
  localparam int FOLD_W     = 128;
  localparam int DEG_W      = 7;
  localparam int TAPN_W     = 3;
  localparam int OP_W       = 2;

  // configuration port
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // reduction polynomial limits
  localparam int MIN_DEGREE = 2;
  localparam int MAX_DEGREE = 120;
  localparam int MAX_TAPS   = 4;
  localparam int NUM_TAPS   = 4;

  // pipeline shape: input stage, multiply stages, two fold stages
  localparam int MUL_STAGES = 4;
  localparam int CHUNK_W    = ELEM_W / MUL_STAGES;
  localparam int PP_W       = ELEM_W + CHUNK_W - 1;
  localparam int NUM_STAGES = MUL_STAGES + 3;

  typedef enum logic [OP_W-1:0] {
    OP_MUL   = 2'd0,
    OP_SQR   = 2'd1,
    OP_TRACE = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEGREE  = 3'd0,
    CFG_TAP_CNT = 3'd1,
    CFG_TAP0    = 3'd2,
    CFG_TAP1    = 3'd3,
    CFG_TAP2    = 3'd4,
    CFG_TAP3    = 3'd5,
    CFG_MASK_LO = 3'd6,
    CFG_MASK_HI = 3'd7
  } cfg_idx_e;

  typedef logic [NUM_TAPS-1:0][DEG_W-1:0] tap_vec_t;

  // contents of one pipeline stage
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] x;
    logic [ELEM_W-1:0] y;
    logic [PROD_W-1:0] acc;
    logic              tbit;
  } stage_t;

  // carry-less product of a full element with one slice of the other operand
  function automatic logic [PP_W-1:0] clmul_chunk(input logic [ELEM_W-1:0]  x,
                                                  input logic [CHUNK_W-1:0] y);
    logic [PP_W-1:0] r;
    r = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (y[i]) begin
        r = r ^ (PP_W'(x) << i);
      end
    end
    return r;
  endfunction

  // xor the high part and its tap-shifted copies into the low part
  function automatic logic [FOLD_W-1:0] fold_in(input logic [FOLD_W-1:0] l,
                                                input logic [FOLD_W-1:0] h,
                                                input logic [TAPN_W-1:0] k,
                                                input tap_vec_t          taps);
    logic [FOLD_W-1:0] r;
    r = l ^ h;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (TAPN_W'(i) < k) begin
        r = r ^ (h << taps[i]);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/gfau_if.sv
interface gfau_in_if;
  import gfau_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [LO_W-1:0]   a_lo;
  logic [HI_W-1:0]   a_hi;
  logic [LO_W-1:0]   b_lo;
  logic [HI_W-1:0]   b_hi;

  modport source (output valid, opcode, a_lo, a_hi, b_lo, b_hi, input ready);
  modport sink   (input valid, opcode, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface gfau_out_if;
  import gfau_pkg::*;

  logic            valid;
  logic            ready;
  logic [LO_W-1:0] result_lo;
  logic [HI_W-1:0] result_hi;
  logic            trace_bit;

  modport source (output valid, result_lo, result_hi, trace_bit, input ready);
  modport sink   (input valid, result_lo, result_hi, trace_bit, output ready);
endinterface

>>> hdl/gf2m_field_arithmetic_unit.sv
// channel   dir  handshake     payload
// in_if     in   valid/ready   opcode, a_lo, a_hi, b_lo, b_hi
// out_if    out  valid/ready   result_lo, result_hi, trace_bit
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// seven register stages: operand capture, four carry-less multiply slices of
// 30 bits each, first fold, second fold; the last stage is the output register
// one item per cycle sustained while out_if.ready stays high
// each stage moves when it is empty or the stage after it moves, so bubbles fill
// under a stalled output and nothing is dropped or repeated
// reset clears valid bits and loads the default configuration; stage payload is not reset
module gf2m_field_arithmetic_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gfau_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gfau_pkg::CFG_W-1:0]     cfg_data_i,
  gfau_in_if.sink                  in_if,
  gfau_out_if.source               out_if
);
  import gfau_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  // configuration registers
  logic [DEG_W-1:0]  degree_q;
  logic [TAPN_W-1:0] tap_cnt_q;
  tap_vec_t          tap_q;
  logic [LO_W-1:0]   mask_lo_q;
  logic [HI_W-1:0]   mask_hi_q;

  // effective polynomial
  logic [DEG_W-1:0]  eff_deg;
  logic [TAPN_W-1:0] eff_taps;
  logic              wide;
  logic [FOLD_W-1:0] low_mask;

  // pipeline
  stage_t                 stage_q [NUM_STAGES];
  stage_t                 stage_d [NUM_STAGES];
  logic [NUM_STAGES-1:0]  valid_q;
  logic [NUM_STAGES-1:0]  adv;

  // fold working values
  logic [PROD_W-1:0] f1_shift;
  logic [FOLD_W-1:0] f1_low;
  logic [FOLD_W-1:0] f2_high;
  logic [FOLD_W-1:0] f2_res;
  logic [ELEM_W-1:0] in_a;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q  <= DEG_W'(2);
      tap_cnt_q <= TAPN_W'(1);
      tap_q     <= {NUM_TAPS{DEG_W'(1)}};
      mask_lo_q <= LO_W'(2);
      mask_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEGREE:  degree_q  <= cfg_data_i[DEG_W-1:0];
        CFG_TAP_CNT: tap_cnt_q <= cfg_data_i[TAPN_W-1:0];
        CFG_TAP0:    tap_q[0]  <= cfg_data_i[DEG_W-1:0];
        CFG_TAP1:    tap_q[1]  <= cfg_data_i[DEG_W-1:0];
        CFG_TAP2:    tap_q[2]  <= cfg_data_i[DEG_W-1:0];
        CFG_TAP3:    tap_q[3]  <= cfg_data_i[DEG_W-1:0];
        CFG_MASK_LO: mask_lo_q <= cfg_data_i[LO_W-1:0];
        CFG_MASK_HI: mask_hi_q <= cfg_data_i[HI_W-1:0];
        default:     degree_q  <= degree_q;
      endcase
    end
  end

  // clamp degree and tap count
  always_comb begin
    if (degree_q < DEG_W'(MIN_DEGREE)) begin
      eff_deg = DEG_W'(MIN_DEGREE);
    end else if (degree_q > DEG_W'(MAX_DEGREE)) begin
      eff_deg = DEG_W'(MAX_DEGREE);
    end else begin
      eff_deg = degree_q;
    end
    eff_taps = (tap_cnt_q > TAPN_W'(MAX_TAPS)) ? TAPN_W'(MAX_TAPS) : tap_cnt_q;
    wide     = eff_deg > DEG_W'(LO_W);
    low_mask = ~({FOLD_W{1'b1}} << eff_deg);
  end

  // stage advance chain, from the output back to the input
  always_comb begin
    adv[LAST] = !valid_q[LAST] || out_if.ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_if.ready = adv[0];

  // next contents of every stage
  always_comb begin
    // operand capture, trace parity and narrow-field masking
    in_a               = {in_if.a_hi, in_if.a_lo};
    stage_d[0].op      = in_if.opcode;
    stage_d[0].x       = in_a;
    stage_d[0].y       = (in_if.opcode == OP_SQR) ? in_a : {in_if.b_hi, in_if.b_lo};
    stage_d[0].acc     = '0;
    stage_d[0].tbit    = ^(in_a & {mask_hi_q, mask_lo_q});
    if (!wide) begin
      stage_d[0].x[ELEM_W-1:LO_W] = '0;
      stage_d[0].y[ELEM_W-1:LO_W] = '0;
    end

    // one operand slice per multiply stage
    for (int s = 1; s <= MUL_STAGES; s++) begin
      stage_d[s]     = stage_q[s-1];
      stage_d[s].acc = stage_q[s-1].acc ^
                       (PROD_W'(clmul_chunk(stage_q[s-1].x,
                                            stage_q[s-1].y[(s-1)*CHUNK_W +: CHUNK_W]))
                        << ((s-1)*CHUNK_W));
    end

    // first fold of the bits at and above the degree
    f1_shift                 = stage_q[MUL_STAGES].acc >> eff_deg;
    f1_low                   = stage_q[MUL_STAGES].acc[FOLD_W-1:0] & low_mask;
    stage_d[MUL_STAGES+1]    = stage_q[MUL_STAGES];
    stage_d[MUL_STAGES+1].acc = PROD_W'(fold_in(f1_low, f1_shift[FOLD_W-1:0],
                                                eff_taps, tap_q));

    // second fold and result selection
    f2_high = stage_q[MUL_STAGES+1].acc[FOLD_W-1:0] >> eff_deg;
    f2_res  = fold_in(stage_q[MUL_STAGES+1].acc[FOLD_W-1:0] & low_mask, f2_high,
                      eff_taps, tap_q);
    stage_d[LAST]      = stage_q[MUL_STAGES+1];
    stage_d[LAST].acc  = '0;
    stage_d[LAST].tbit = 1'b0;
    if (stage_q[MUL_STAGES+1].op == OP_MUL || stage_q[MUL_STAGES+1].op == OP_SQR) begin
      stage_d[LAST].acc = PROD_W'(f2_res);
    end
    if (stage_q[MUL_STAGES+1].op == OP_TRACE) begin
      stage_d[LAST].tbit = stage_q[MUL_STAGES+1].tbit;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_if.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (adv[s]) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  // output channel
  assign out_if.valid     = valid_q[LAST];
  assign out_if.result_lo = stage_q[LAST].acc[LO_W-1:0];
  assign out_if.result_hi = stage_q[LAST].acc[ELEM_W-1:LO_W];
  assign out_if.trace_bit = stage_q[LAST].tbit;

endmodule

>>> sim/gfau_checker.sv
`timescale 1ns / 100ps
module gfau_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gfau_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gfau_pkg::CFG_W-1:0]     cfg_data_i,
  gfau_in_if                             in_mon,
  gfau_out_if                            out_mon,
  output int                             fail_cnt_o,
  output int                             pending_o
);
  import gfau_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int WIDE_W      = 2 * FOLD_W;

  typedef struct packed {
    logic [LO_W-1:0] res_lo;
    logic [HI_W-1:0] res_hi;
    logic            tbit;
  } field_result_t;

  // copy of the field configuration as the unit should hold it
  logic [DEG_W-1:0]  degree;
  logic [TAPN_W-1:0] tap_cnt;
  logic [DEG_W-1:0]  tap_exp [NUM_TAPS];
  logic [LO_W-1:0]   tmask_lo;
  logic [HI_W-1:0]   tmask_hi;

  field_result_t expected_q [$];
  field_result_t oldest;

  // degree and tap count as the unit clamps them
  function automatic int unsigned active_degree();
    if (degree < MIN_DEGREE) return MIN_DEGREE;
    if (degree > MAX_DEGREE) return MAX_DEGREE;
    return int'(degree);
  endfunction

  function automatic int unsigned active_taps();
    return (tap_cnt > MAX_TAPS) ? MAX_TAPS : int'(tap_cnt);
  endfunction

  // full carry-less product of two elements
  function automatic logic [WIDE_W-1:0] clmul_elem(input logic [ELEM_W-1:0] x,
                                                   input logic [ELEM_W-1:0] y);
    logic [WIDE_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < ELEM_W; i++) begin
      if (y[i]) begin
        acc = acc ^ (WIDE_W'(x) << i);
      end
    end
    return acc;
  endfunction

  // high part goes back in at x^0 and at every active tap, past bit 127 is lost
  function automatic logic [FOLD_W-1:0] add_taps(input logic [FOLD_W-1:0] l,
                                                 input logic [FOLD_W-1:0] h);
    logic [FOLD_W-1:0] r;
    int unsigned       k;
    k = active_taps();
    r = l ^ h;
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (i < k) begin
        r = r ^ (h << tap_exp[i]);
      end
    end
    return r;
  endfunction

  // two folding passes, no check that the result ends below x^m
  function automatic logic [FOLD_W-1:0] reduce_mod_f(input logic [WIDE_W-1:0] v);
    int unsigned       m;
    logic [FOLD_W-1:0] keep;
    logic [FOLD_W-1:0] low;
    logic [FOLD_W-1:0] high;
    m = active_degree();
    keep = (FOLD_W'(1) << m) - FOLD_W'(1);
    high = FOLD_W'(v >> m);
    low = add_taps(v[FOLD_W-1:0] & keep, high);
    high = low >> m;
    return add_taps(low & keep, high);
  endfunction

  // expected result item for one operation item
  function automatic field_result_t predict_field_op(input logic [OP_W-1:0] op,
                                                     input logic [LO_W-1:0] a_lo,
                                                     input logic [HI_W-1:0] a_hi,
                                                     input logic [LO_W-1:0] b_lo,
                                                     input logic [HI_W-1:0] b_hi);
    field_result_t     r;
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic [FOLD_W-1:0] v;
    r = '0;
    a = {a_hi, a_lo};
    b = {b_hi, b_lo};
    // small fields multiply the low halves only
    if (active_degree() <= LO_W) begin
      a[ELEM_W-1:LO_W] = '0;
      b[ELEM_W-1:LO_W] = '0;
    end
    case (op) inside
      OP_MUL, OP_SQR: begin
        v = reduce_mod_f(clmul_elem(a, (op == OP_SQR) ? a : b));
        r.res_lo = v[LO_W-1:0];
        r.res_hi = v[ELEM_W-1:LO_W];
      end
      OP_TRACE: begin
        r.tbit = ^{a_hi & tmask_hi, a_lo & tmask_lo};
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree     <= DEG_W'(MIN_DEGREE);
      tap_cnt    <= TAPN_W'(1);
      tap_exp    <= '{default: DEG_W'(1)};
      tmask_lo   <= LO_W'(2);
      tmask_hi   <= '0;
      expected_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      // result item leaving the unit
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= MAX_REPORTS) begin
            $display("%0t: result item with none pending: lo=%h hi=%h trace=%b", $time,
                     out_mon.result_lo, out_mon.result_hi, out_mon.trace_bit);
          end
        end else begin
          oldest = expected_q.pop_front();
          if (out_mon.result_lo !== oldest.res_lo || out_mon.result_hi !== oldest.res_hi ||
              out_mon.trace_bit !== oldest.tbit) begin
            fail_cnt_o++;
            if (fail_cnt_o <= MAX_REPORTS) begin
              $display("%0t: result mismatch: expected lo=%h hi=%h trace=%b", $time,
                       oldest.res_lo, oldest.res_hi, oldest.tbit);
              $display("%0t:                  got      lo=%h hi=%h trace=%b", $time,
                       out_mon.result_lo, out_mon.result_hi, out_mon.trace_bit);
            end
          end
        end
      end

      // operation item entering the unit
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_field_op(in_mon.opcode, in_mon.a_lo, in_mon.a_hi,
                                              in_mon.b_lo, in_mon.b_hi));
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEGREE:  degree     <= cfg_data_i[DEG_W-1:0];
          CFG_TAP_CNT: tap_cnt    <= cfg_data_i[TAPN_W-1:0];
          CFG_TAP0:    tap_exp[0] <= cfg_data_i[DEG_W-1:0];
          CFG_TAP1:    tap_exp[1] <= cfg_data_i[DEG_W-1:0];
          CFG_TAP2:    tap_exp[2] <= cfg_data_i[DEG_W-1:0];
          CFG_TAP3:    tap_exp[3] <= cfg_data_i[DEG_W-1:0];
          CFG_MASK_LO: tmask_lo   <= cfg_data_i[LO_W-1:0];
          CFG_MASK_HI: tmask_hi   <= cfg_data_i[HI_W-1:0];
          default: ;
        endcase
      end

      pending_o = expected_q.size();
    end
  end

endmodule

>>> sim/tb_gf2m_field_arithmetic_unit.sv
`timescale 1ns / 100ps
module tb_gf2m_field_arithmetic_unit;
  import gfau_pkg::*;

  localparam int IDLE_MAX     = 12;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 500;

  // opcode the unit does not define
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_cnt;
  int                   pending;
  int unsigned          cur_deg = MIN_DEGREE;
  int unsigned          random_sent = 0;
  int unsigned          hold_req = 0;
  int unsigned          cycle_cnt = 0;
  bit                   tx_idle = 1'b1;
  bit                   rx_idle = 1'b1;

  gfau_in_if  in_ch ();
  gfau_out_if out_ch ();

  gf2m_field_arithmetic_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  gfau_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_gf2m_field_arithmetic_unit NOT OK");
    $finish;
  end

  // result side: random stalls per item, long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req > holds_done) begin
        holds_done++;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && hold_req == holds_done);
    end
  end

  function automatic int unsigned clamp_degree(input logic [DEG_W-1:0] d);
    if (d < MIN_DEGREE) return MIN_DEGREE;
    if (d > MAX_DEGREE) return MAX_DEGREE;
    return int'(d);
  endfunction

  // mostly elements below x^m, some oversized, sparse or saturated
  function automatic logic [ELEM_W-1:0] draw_element();
    logic [ELEM_W-1:0] e;
    e = ELEM_W'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: e = e & ((ELEM_W'(1) << cur_deg) - ELEM_W'(1));
      5:             e = ELEM_W'(1) << $urandom_range(0, ELEM_W - 1);
      6:             e = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return e;
  endfunction

  // offer one item, valid stays high when the next one follows at once
  task automatic put_item(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] a,
                          input logic [ELEM_W-1:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode <= op;
    in_ch.a_lo   <= a[LO_W-1:0];
    in_ch.a_hi   <= a[ELEM_W-1:LO_W];
    in_ch.b_lo   <= b[LO_W-1:0];
    in_ch.b_hi   <= b[ELEM_W-1:LO_W];
    in_ch.valid  <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // drain the unit, then load a new reduction polynomial and trace mask
  task automatic set_field(input logic [CFG_W-1:0] deg_w, input logic [CFG_W-1:0] cnt_w,
                           input logic [CFG_W-1:0] t0, input logic [CFG_W-1:0] t1,
                           input logic [CFG_W-1:0] t2, input logic [CFG_W-1:0] t3,
                           input logic [CFG_W-1:0] mlo, input logic [CFG_W-1:0] mhi);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    write_reg(CFG_DEGREE, deg_w);
    write_reg(CFG_TAP_CNT, cnt_w);
    write_reg(CFG_TAP0, t0);
    write_reg(CFG_TAP1, t1);
    write_reg(CFG_TAP2, t2);
    write_reg(CFG_TAP3, t3);
    write_reg(CFG_MASK_LO, mlo);
    write_reg(CFG_MASK_HI, mhi);
    cur_deg = clamp_degree(deg_w[DEG_W-1:0]);
  endtask

  // random polynomial, degree often at a boundary, junk above the register width
  task automatic random_field();
    logic [CFG_W-1:0] deg_w;
    logic [CFG_W-1:0] cnt_w;
    logic [CFG_W-1:0] tap_w [NUM_TAPS];
    int unsigned      m;
    case ($urandom_range(0, 3))
      0:       deg_w = CFG_W'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                                   : $urandom_range(119, 127));
      1:       deg_w = CFG_W'($urandom_range(62, 66));
      default: deg_w = CFG_W'($urandom_range(MIN_DEGREE, MAX_DEGREE));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      deg_w = ({$urandom, $urandom} << DEG_W) | deg_w;
    end
    m = clamp_degree(deg_w[DEG_W-1:0]);
    cnt_w = CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
    for (int i = 0; i < NUM_TAPS; i++) begin
      tap_w[i] = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, m - 1));
    end
    set_field(deg_w, cnt_w, tap_w[0], tap_w[1], tap_w[2], tap_w[3],
              {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // saturated operands, every opcode, reduction of x^m
  task automatic corner_items();
    logic [ELEM_W-1:0] ones;
    logic [ELEM_W-1:0] top_bit;
    ones = '1;
    top_bit = ELEM_W'(1) << (cur_deg - 1);
    put_item(OP_MUL, ones, ones);
    put_item(OP_SQR, ones, '0);
    put_item(OP_TRACE, ones, ones);
    put_item(OP_UNDEF, ones, ones);
    put_item(OP_MUL, '0, draw_element());
    put_item(OP_MUL, top_bit, ELEM_W'(2));
  endtask

  task automatic random_burst(input int unsigned n);
    logic [OP_W-1:0] op;
    int unsigned     pick;
    repeat (n) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        op = OP_UNDEF;
      end else if (pick < 8) begin
        op = OP_MUL;
      end else if (pick < 12) begin
        op = OP_SQR;
      end else begin
        op = OP_TRACE;
      end
      put_item(op, draw_element(), draw_element());
      random_sent++;
    end
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_MUL;
    in_ch.a_lo   <= '0;
    in_ch.a_hi   <= '0;
    in_ch.b_lo   <= '0;
    in_ch.b_hi   <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_DEGREE;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field as it comes out of reset
    corner_items();
    random_burst(24);

    // degree and tap count past their limits, taps at zero and beyond the field
    set_field(127, 7, 0, 127, 64, 119, '1, '1);
    corner_items();
    random_burst(30);

    // degree below two with no middle terms
    set_field(0, 0, 1, 1, 1, 1, 64'h5555_5555_5555_5555, 64'hffff_ffff_ffff_ffff);
    corner_items();
    random_burst(20);

    // widest field on the low halves alone, no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_field(64, 4, 4, 3, 1, 63, {$urandom, $urandom}, {$urandom, $urandom});
    random_burst(30);

    // narrowest field that uses the high halves, only the sender idles
    tx_idle = 1'b1;
    set_field(65, 2, 18, 64, 1, 1, {$urandom, $urandom}, {$urandom, $urandom});
    random_burst(30);

    // full width field, results held off while items stream in
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    set_field(120, 4, 1, 2, 3, 119, {$urandom, $urandom}, {$urandom, $urandom});
    hold_req++;
    random_burst(40);

    // trinomial of degree 113, then degree one, which the unit clamps to two
    tx_idle = 1'b1;
    set_field(113, 1, 9, 0, 0, 0, {$urandom, $urandom}, {$urandom, $urandom});
    random_burst(30);
    set_field(1, 3, 1, 1, 0, 2, {$urandom, $urandom}, {$urandom, $urandom});
    random_burst(20);

    // random polynomials and idling mixes
    while (random_sent < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      random_field();
      random_burst($urandom_range(15, 40));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_gf2m_field_arithmetic_unit OK");
    end else begin
      $display("tb_gf2m_field_arithmetic_unit NOT OK");
    end
    $finish;
  end

endmodule
